// File: rtl/ccm_pkg.sv
// ----------------------------------------------------------------------------
// ccm_pkg: shared types and constants of the calendar clock
// Request and time structs, command and status codes, calendar constants and
// the month length and leap year helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package ccm_pkg;

  typedef enum logic {
    CmdTick = 1'b0,
    CmdSet  = 1'b1
  } ccm_cmd_e;

  typedef enum logic [1:0] {
    StTickDone = 2'd0,
    StSetOk    = 2'd1,
    StSetBad   = 2'd2
  } ccm_status_e;

  typedef struct packed {
    ccm_cmd_e   cmd;
    logic [9:0] elapsed_ms;
    logic [13:0] set_year;
    logic [6:0] set_month;
    logic [6:0] set_day;
    logic [6:0] set_hour;
    logic [6:0] set_minute;
    logic [6:0] set_second;
  } ccm_req_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  millis;
  } ccm_time_t;

  localparam logic [9:0]  ElapsedMax = 10'd999;
  localparam logic [10:0] MsPerSec   = 11'd1000;
  localparam logic [5:0]  SecMax     = 6'd59;
  localparam logic [5:0]  MinMax     = 6'd59;
  localparam logic [4:0]  HourMax    = 5'd23;
  localparam logic [3:0]  MonthMax   = 4'd12;
  localparam logic [3:0]  MonthFeb   = 4'd2;
  localparam logic [13:0] YearMax    = 14'd9999;

  // y divisible by 25 iff y * inv(25) mod 2^16 <= (2^16 - 1) / 25
  localparam logic [15:0] Inv25      = 16'd23593;
  localparam logic [15:0] Div25Lim   = 16'd2621;

  localparam logic [4:0] MonthLen [16] = '{
    5'd30, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd30, 5'd30, 5'd30
  };

  localparam ccm_time_t ResetTime = '{
    year:   14'd2026,
    month:  4'd4,
    day:    5'd22,
    hour:   5'd16,
    minute: 6'd0,
    second: 6'd0,
    millis: 10'd0
  };

  function automatic logic is_leap(input logic [13:0] y);
    logic [15:0] prod;
    logic        div25;
    prod  = {2'b00, y} * Inv25;
    div25 = (prod <= Div25Lim);
    // century years need divisibility by 16 as well (400 = 16 * 25)
    return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
  endfunction

  function automatic logic [4:0] days_in(input logic [13:0] y, input logic [3:0] m);
    logic [4:0] len;
    if (m == MonthFeb) begin
      len = is_leap(y) ? 5'd29 : 5'd28;
    end else begin
      len = MonthLen[m];
    end
    return len;
  endfunction

endpackage

`default_nettype wire

// File: rtl/ccm_in_stage.sv
// ----------------------------------------------------------------------------
// ccm_in_stage: input register of the calendar clock
// Captures one request and holds it until the update stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ccm_in_stage (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  ccm_pkg::ccm_req_t  req_i,
  input  wire                take_i,
  output logic               valid_o,
  output ccm_pkg::ccm_req_t  req_o
);

  logic              valid_d, valid_q;
  ccm_pkg::ccm_req_t req_q;
  logic              load;

  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      req_q <= req_i;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

`default_nettype wire

// File: rtl/ccm_next.sv
// ----------------------------------------------------------------------------
// ccm_next: next clock value for one request
// Millisecond accumulate with one-second ripple through the calendar, or a
// checked load of a new date and time.
// ----------------------------------------------------------------------------
`default_nettype none

module ccm_next (
  input  ccm_pkg::ccm_time_t   cur_i,
  input  ccm_pkg::ccm_req_t    req_i,
  output ccm_pkg::ccm_time_t   nxt_o,
  output ccm_pkg::ccm_status_e status_o
);

  logic [9:0]  elapsed;
  logic [10:0] ms_sum;
  logic        carry;
  logic [9:0]  ms_new;
  logic [4:0]  cur_dim;
  logic [4:0]  set_dim;
  logic        set_ok;

  // out-of-range elapsed values saturate
  assign elapsed = (req_i.elapsed_ms > ccm_pkg::ElapsedMax) ? ccm_pkg::ElapsedMax
                                                             : req_i.elapsed_ms;
  assign ms_sum  = {1'b0, cur_i.millis} + {1'b0, elapsed};
  assign carry   = (ms_sum >= ccm_pkg::MsPerSec);
  assign ms_new  = carry ? 10'(ms_sum - ccm_pkg::MsPerSec) : ms_sum[9:0];

  assign cur_dim = ccm_pkg::days_in(cur_i.year, cur_i.month);
  assign set_dim = ccm_pkg::days_in(req_i.set_year, req_i.set_month[3:0]);

  assign set_ok = (req_i.set_year <= ccm_pkg::YearMax)
               && (req_i.set_month >= 7'd1)
               && (req_i.set_month <= 7'(ccm_pkg::MonthMax))
               && (req_i.set_day >= 7'd1)
               && (req_i.set_day <= {2'b00, set_dim})
               && (req_i.set_hour <= 7'(ccm_pkg::HourMax))
               && (req_i.set_minute <= 7'(ccm_pkg::MinMax))
               && (req_i.set_second <= 7'(ccm_pkg::SecMax));

  always_comb begin
    nxt_o    = cur_i;
    status_o = ccm_pkg::StTickDone;
    if (req_i.cmd == ccm_pkg::CmdTick) begin
      nxt_o.millis = ms_new;
      if (carry) begin
        if (cur_i.second >= ccm_pkg::SecMax) begin
          nxt_o.second = 6'd0;
          if (cur_i.minute >= ccm_pkg::MinMax) begin
            nxt_o.minute = 6'd0;
            if (cur_i.hour >= ccm_pkg::HourMax) begin
              nxt_o.hour = 5'd0;
              if (cur_i.day >= cur_dim) begin
                nxt_o.day = 5'd1;
                if (cur_i.month >= ccm_pkg::MonthMax) begin
                  nxt_o.month = 4'd1;
                  nxt_o.year  = (cur_i.year >= ccm_pkg::YearMax) ? 14'd0
                                                                 : cur_i.year + 14'd1;
                end else begin
                  nxt_o.month = cur_i.month + 4'd1;
                end
              end else begin
                nxt_o.day = cur_i.day + 5'd1;
              end
            end else begin
              nxt_o.hour = cur_i.hour + 5'd1;
            end
          end else begin
            nxt_o.minute = cur_i.minute + 6'd1;
          end
        end else begin
          nxt_o.second = cur_i.second + 6'd1;
        end
      end
    end else if (set_ok) begin
      nxt_o.year   = req_i.set_year;
      nxt_o.month  = req_i.set_month[3:0];
      nxt_o.day    = req_i.set_day[4:0];
      nxt_o.hour   = req_i.set_hour[4:0];
      nxt_o.minute = req_i.set_minute[5:0];
      nxt_o.second = req_i.set_second[5:0];
      nxt_o.millis = 10'd0;
      status_o     = ccm_pkg::StSetOk;
    end else begin
      status_o     = ccm_pkg::StSetBad;
    end
  end

endmodule

`default_nettype wire

// File: rtl/calendar_clock_ms_tick.sv
// ----------------------------------------------------------------------------
// calendar_clock_ms_tick: Gregorian real-time calendar clock
// Millisecond tick accumulation with calendar rollover and checked time set.
// ----------------------------------------------------------------------------
// One request per clock cycle is sustained while the result channel is not stalled.
// A request is held in the input register; the clock update and the write
// of the result register follow once the result register is empty or being
// drained. The combinational ripple from seconds through years, including
// the leap year test, sets the cycle time. Reset starts the clock at
// 2026-04-22 16:00:00.000 and needs no clearing time.
`default_nettype none

module calendar_clock_ms_tick (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire         cmd_i,
  input  wire  [9:0]  elapsed_ms_i,
  input  wire  [13:0] set_year_i,
  input  wire  [6:0]  set_month_i,
  input  wire  [6:0]  set_day_i,
  input  wire  [6:0]  set_hour_i,
  input  wire  [6:0]  set_minute_i,
  input  wire  [6:0]  set_second_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [13:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_o,
  output logic [4:0]  hour_o,
  output logic [5:0]  minute_o,
  output logic [5:0]  second_o,
  output logic [9:0]  millis_o,
  output logic [1:0]  status_o
);

  ccm_pkg::ccm_req_t    req_in;
  ccm_pkg::ccm_req_t    req_q;
  logic                 req_valid;
  logic                 advance;
  logic                 fire;
  ccm_pkg::ccm_time_t   state_d, state_q;
  ccm_pkg::ccm_status_e status_d;
  ccm_pkg::ccm_time_t   res_time_q;
  ccm_pkg::ccm_status_e res_status_q;
  logic                 out_valid_d, out_valid_q;

  assign req_in = '{
    cmd:        ccm_pkg::ccm_cmd_e'(cmd_i),
    elapsed_ms: elapsed_ms_i,
    set_year:   set_year_i,
    set_month:  set_month_i,
    set_day:    set_day_i,
    set_hour:   set_hour_i,
    set_minute: set_minute_i,
    set_second: set_second_i
  };

  // result register frees up when empty or being drained
  assign advance = !out_valid_q || out_ready_i;
  assign fire    = req_valid && advance;

  ccm_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_i      (req_in),
    .take_i     (fire),
    .valid_o    (req_valid),
    .req_o      (req_q)
  );

  ccm_next u_next (
    .cur_i    (state_q),
    .req_i    (req_q),
    .nxt_o    (state_d),
    .status_o (status_d)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ccm_pkg::ResetTime;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (fire) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_time_q   <= state_d;
      res_status_q <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign year_o      = res_time_q.year;
  assign month_o     = res_time_q.month;
  assign day_o       = res_time_q.day;
  assign hour_o      = res_time_q.hour;
  assign minute_o    = res_time_q.minute;
  assign second_o    = res_time_q.second;
  assign millis_o    = res_time_q.millis;
  assign status_o    = res_status_q;

endmodule

`default_nettype wire

// File: rtl/ccm_checker.sv
// ----------------------------------------------------------------------------
// ccm_checker: port-level checks for the calendar clock
// Watches the result channel for stalls and out-of-range clock values, and checks input back-pressure and set clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module ccm_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_ready_o,
  input wire        out_valid_o,
  input wire        out_ready_i,
  input wire [13:0] year_o,
  input wire [3:0]  month_o,
  input wire [4:0]  day_o,
  input wire [4:0]  hour_o,
  input wire [5:0]  minute_o,
  input wire [5:0]  second_o,
  input wire [9:0]  millis_o,
  input wire [1:0]  status_o
);

  // a stalled result stays valid and holds year, month, day, second, millis and status
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(year_o) && $stable(month_o)
      && $stable(day_o) && $stable(second_o) && $stable(millis_o) && $stable(status_o))
    else $error("result changed while stalled");

  // no shown field lies outside its fixed range; the day is only checked to be nonzero
  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> year_o <= 14'd9999 && month_o >= 4'd1 && month_o <= 4'd12
      && day_o >= 5'd1 && hour_o <= 5'd23 && minute_o <= 6'd59 && second_o <= 6'd59
      && millis_o <= 10'd999)
    else $error("clock value out of range");

  // accepted set clears the accumulator
  a_set_clears_ms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ccm_pkg::StSetOk |-> millis_o == 10'd0)
    else $error("accepted set left milliseconds");

  // a blocked input means a result is waiting and stalled
  a_ready_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input blocked with no stalled result");

endmodule

bind calendar_clock_ms_tick ccm_checker u_ccm_checker (.*);

`default_nettype wire
